/* design/mtff_pkg.sv */
// Shared constants, types and helpers for the min-tree first-fit engine.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package mtff_pkg;

    // Tree geometry: leaf i sits at node LEAF_SLOTS + i, node 1 is the root
    localparam int LEAF_SLOTS = 1024;
    localparam int LEVELS     = $clog2(LEAF_SLOTS);
    localparam int NODE_W     = LEVELS + 1;
    localparam int NODES      = 2 * LEAF_SLOTS;

    // Field widths
    localparam int FUNC_W = 2;
    localparam int POS_W  = 10;
    localparam int DATA_W = 32;

    // Value codes
    localparam logic [DATA_W-1:0] EMPTY_MARK = 32'hFFFF_FFFF;
    localparam logic [DATA_W-1:0] TOP_VALUE  = 32'hFFFF_FFFE;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd2;

    // Tree memory request: one read address, one write port
    typedef struct packed {
        logic [NODE_W-1:0] rd_addr;
        logic              wr_en;
        logic [NODE_W-1:0] wr_addr;
        logic [DATA_W-1:0] wr_data;
    } ram_req_t;

    // Shared compare unit result
    typedef struct packed {
        logic              le;
        logic [DATA_W-1:0] min_val;
    } cmp_res_t;

    // Node number of a leaf slot
    function automatic logic [NODE_W-1:0] leaf_node(input logic [POS_W-1:0] p);
        return NODE_W'(LEAF_SLOTS) | NODE_W'(p);
    endfunction

endpackage

`default_nettype wire

/* design/mtff_tree_ram.sv */
// Tree memory holding the minimum of every node, one write and one read port.
// Depends on mtff_pkg for geometry and the request struct.
`default_nettype none

module mtff_tree_ram (
    input  wire logic                      clk,
    input  wire mtff_pkg::ram_req_t        req,
    output logic [mtff_pkg::DATA_W-1:0]    rd_data
);

    logic [mtff_pkg::DATA_W-1:0] mem [mtff_pkg::NODES];

    // Write one node per cycle
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        rd_data <= mem[req.rd_addr];
    end

endmodule

`default_nettype wire

/* design/mtff_cmp.sv */
// Shared unsigned compare and minimum unit used by both update and search.
// Depends on mtff_pkg for the result struct.
`default_nettype none

module mtff_cmp (
    input  wire logic [mtff_pkg::DATA_W-1:0] a,
    input  wire logic [mtff_pkg::DATA_W-1:0] b,
    output mtff_pkg::cmp_res_t               res
);

    // Compare memory word against threshold or running minimum
    always_comb
    begin
        res.le      = (a <= b);
        res.min_val = res.le ? a : b;
    end

endmodule

`default_nettype wire

/* design/mtff_seq.sv */
// Sequencer: clearing pass, path update for load/remove, first-fit search,
// and the input/output handshakes. Depends on mtff_pkg.
`default_nettype none

module mtff_seq (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [mtff_pkg::FUNC_W-1:0]   func,
    input  wire logic [mtff_pkg::POS_W-1:0]    position,
    input  wire logic [mtff_pkg::POS_W-1:0]    range_end,
    input  wire logic [mtff_pkg::DATA_W-1:0]   leaf_value,
    input  wire logic [mtff_pkg::DATA_W-1:0]   threshold,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               found,
    output logic [mtff_pkg::POS_W-1:0]         match_index,
    output logic [mtff_pkg::DATA_W-1:0]        match_value,
    output mtff_pkg::ram_req_t                 ram_req,
    input  wire logic [mtff_pkg::DATA_W-1:0]   rd_data,
    output logic [mtff_pkg::DATA_W-1:0]        cmp_b,
    input  wire mtff_pkg::cmp_res_t            cmp_res
);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_START = 8'b0000_0100,
        S_UPD   = 8'b0000_1000,
        S_FTEST = 8'b0001_0000,
        S_FUP   = 8'b0010_0000,
        S_FDESC = 8'b0100_0000,
        S_FLEAF = 8'b1000_0000
    } state_t;

    // Result hand-off: working, or holding a finished result for the output register
    typedef enum logic [1:0] {
        H_BUSY = 2'b01,
        H_DONE = 2'b10
    } hand_t;

    state_t                       state_reg, state_next;
    hand_t                        hand_reg, hand_next;
    logic [mtff_pkg::NODE_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic                         out_valid_reg, out_valid_next;

    logic [mtff_pkg::FUNC_W-1:0]  func_reg, func_next;
    logic [mtff_pkg::POS_W-1:0]   lo_reg, lo_next;
    logic [mtff_pkg::POS_W-1:0]   hi_reg, hi_next;
    logic [mtff_pkg::DATA_W-1:0]  val_reg, val_next;
    logic [mtff_pkg::DATA_W-1:0]  thr_reg, thr_next;
    logic [mtff_pkg::NODE_W-1:0]  node_reg, node_next;
    logic                         res_found_reg, res_found_next;
    logic [mtff_pkg::POS_W-1:0]   res_idx_reg, res_idx_next;
    logic [mtff_pkg::DATA_W-1:0]  res_val_reg, res_val_next;
    logic                         out_found_reg, out_found_next;
    logic [mtff_pkg::POS_W-1:0]   out_idx_reg, out_idx_next;
    logic [mtff_pkg::DATA_W-1:0]  out_val_reg, out_val_next;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            hand_reg      <= H_BUSY;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hand_reg      <= hand_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        val_reg       <= val_next;
        thr_reg       <= thr_next;
        node_reg      <= node_next;
        res_found_reg <= res_found_next;
        res_idx_reg   <= res_idx_next;
        res_val_reg   <= res_val_next;
        out_found_reg <= out_found_next;
        out_idx_reg   <= out_idx_next;
        out_val_reg   <= out_val_next;
    end

    // Sequencer next-state logic
    always_comb
    begin
        logic [mtff_pkg::NODE_W-1:0] leaf;
        logic [mtff_pkg::NODE_W-1:0] parent;
        logic [mtff_pkg::NODE_W-1:0] child;
        logic                        pos_ok;
        logic                        in_range;

        state_next     = state_reg;
        hand_next      = hand_reg;
        clr_cnt_next   = clr_cnt_reg;
        out_valid_next = out_valid_reg;
        func_next      = func_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        val_next       = val_reg;
        thr_next       = thr_reg;
        node_next      = node_reg;
        res_found_next = res_found_reg;
        res_idx_next   = res_idx_reg;
        res_val_next   = res_val_reg;
        out_found_next = out_found_reg;
        out_idx_next   = out_idx_reg;
        out_val_next   = out_val_reg;

        ram_req.rd_addr = '0;
        ram_req.wr_en   = 1'b0;
        ram_req.wr_addr = '0;
        ram_req.wr_data = '0;
        cmp_b           = thr_reg;
        in_ready        = 1'b0;

        leaf     = mtff_pkg::leaf_node(lo_reg);
        parent   = node_reg >> 1;
        child    = node_reg << 1;
        pos_ok   = (32'(lo_reg) < 32'(mtff_pkg::LEAF_SLOTS));
        in_range = (32'(node_reg[mtff_pkg::LEVELS-1:0]) <= 32'(hi_reg));

        // Drop the result beat once taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                // Sweep every node to empty
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = clr_cnt_reg;
                ram_req.wr_data = mtff_pkg::EMPTY_MARK;
                clr_cnt_next    = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (hand_reg == H_DONE)
                begin
                    // Hand the finished result to the output register
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_next = 1'b1;
                        out_found_next = res_found_reg;
                        out_idx_next   = res_idx_reg;
                        out_val_next   = res_val_reg;
                        hand_next      = H_BUSY;
                    end
                end
                else
                begin
                    // Capture an input beat, clamping range and values
                    in_ready = 1'b1;
                    if (in_valid)
                    begin
                        func_next = func;
                        lo_next   = position;
                        if (32'(range_end) >= 32'(mtff_pkg::LEAF_SLOTS))
                        begin
                            hi_next = mtff_pkg::POS_W'(mtff_pkg::LEAF_SLOTS - 1);
                        end
                        else
                        begin
                            hi_next = range_end;
                        end
                        if (func == mtff_pkg::FUNC_REMOVE)
                        begin
                            val_next = mtff_pkg::EMPTY_MARK;
                        end
                        else if (leaf_value == mtff_pkg::EMPTY_MARK)
                        begin
                            val_next = mtff_pkg::TOP_VALUE;
                        end
                        else
                        begin
                            val_next = leaf_value;
                        end
                        thr_next = (threshold == mtff_pkg::EMPTY_MARK) ?
                                   mtff_pkg::TOP_VALUE : threshold;
                        state_next = S_START;
                    end
                end
            end

            S_START:
            begin
                res_found_next = 1'b0;
                res_idx_next   = '0;
                res_val_next   = '0;
                if ((func_reg == mtff_pkg::FUNC_LOAD ||
                     func_reg == mtff_pkg::FUNC_REMOVE) && pos_ok)
                begin
                    // Write the leaf and fetch its sibling
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_addr = leaf;
                    ram_req.wr_data = val_reg;
                    ram_req.rd_addr = leaf ^ mtff_pkg::NODE_W'(1);
                    node_next       = leaf;
                    state_next      = S_UPD;
                end
                else if (func_reg == mtff_pkg::FUNC_FIND && pos_ok &&
                         lo_reg <= hi_reg)
                begin
                    // Test the start leaf first
                    ram_req.rd_addr = leaf;
                    node_next       = leaf;
                    state_next      = S_FTEST;
                end
                else
                begin
                    hand_next  = H_DONE;
                    state_next = S_IDLE;
                end
            end

            S_UPD:
            begin
                // Parent gets the smaller of running value and sibling
                cmp_b           = val_reg;
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = parent;
                ram_req.wr_data = cmp_res.min_val;
                if (parent == mtff_pkg::NODE_W'(1))
                begin
                    hand_next  = H_DONE;
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_req.rd_addr = parent ^ mtff_pkg::NODE_W'(1);
                    val_next        = cmp_res.min_val;
                    node_next       = parent;
                end
            end

            S_FTEST:
            begin
                if (cmp_res.le)
                begin
                    if (node_reg[mtff_pkg::NODE_W-1])
                    begin
                        // Leaf hit: accept only inside the range
                        res_found_next = in_range;
                        res_idx_next   = in_range ?
                            mtff_pkg::POS_W'(node_reg[mtff_pkg::LEVELS-1:0]) : '0;
                        res_val_next   = in_range ? rd_data : '0;
                        hand_next      = H_DONE;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        // Descend into this subtree
                        ram_req.rd_addr = child;
                        state_next      = S_FDESC;
                    end
                end
                else
                begin
                    state_next = S_FUP;
                end
            end

            S_FUP:
            begin
                // Backtrack to the next right sibling
                if (node_reg == mtff_pkg::NODE_W'(1))
                begin
                    hand_next  = H_DONE;
                    state_next = S_IDLE;
                end
                else if (!node_reg[0])
                begin
                    ram_req.rd_addr = node_reg | mtff_pkg::NODE_W'(1);
                    node_next       = node_reg | mtff_pkg::NODE_W'(1);
                    state_next      = S_FTEST;
                end
                else
                begin
                    node_next = parent;
                end
            end

            S_FDESC:
            begin
                logic [mtff_pkg::NODE_W-1:0] d_next;
                // Left child wins when it fits, else the right child must
                d_next    = cmp_res.le ? child : (child | mtff_pkg::NODE_W'(1));
                node_next = d_next;
                if (d_next[mtff_pkg::NODE_W-1])
                begin
                    ram_req.rd_addr = d_next;
                    state_next      = S_FLEAF;
                end
                else
                begin
                    ram_req.rd_addr = d_next << 1;
                end
            end

            S_FLEAF:
            begin
                res_found_next = in_range;
                res_idx_next   = in_range ?
                    mtff_pkg::POS_W'(node_reg[mtff_pkg::LEVELS-1:0]) : '0;
                res_val_next   = in_range ? rd_data : '0;
                hand_next      = H_DONE;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign found       = out_found_reg;
    assign match_index = out_idx_reg;
    assign match_value = out_val_reg;

endmodule

`default_nettype wire

/* design/min_tree_first_fit_engine_core.sv */
// Top level of the min-tree first-fit engine: sequencer, compare unit, tree memory.
// Depends on mtff_pkg, mtff_seq, mtff_cmp and mtff_tree_ram.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one operation per beat: func
//   selects load, remove or find; position is the leaf (or range start),
//   range_end the last leaf searched, leaf_value the value loaded and
//   threshold the find limit. Output channel (out_valid/out_ready) returns
//   exactly one beat per input beat: found, match_index, match_value, all
//   zero for load, remove and unused codes.
//   One operation is in flight at a time; in_ready is low while it runs.
//   Load/remove: the leaf and then its path to the root are written, one
//   tree level per cycle through the memory's read and write ports.
//   Find: a descend/backtrack walk over the tree, reading nodes through
//   the memory's read port.
//   Reset: a clearing pass writes all 2*LEAF_SLOTS nodes to empty, with
//   in_ready low throughout.
//   A stalled receiver holds the result in the output register; the next
//   beat is accepted meanwhile, and its result waits until that one is taken.
`default_nettype none

module min_tree_first_fit_engine_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [mtff_pkg::FUNC_W-1:0]   func,
    input  wire logic [mtff_pkg::POS_W-1:0]    position,
    input  wire logic [mtff_pkg::POS_W-1:0]    range_end,
    input  wire logic [mtff_pkg::DATA_W-1:0]   leaf_value,
    input  wire logic [mtff_pkg::DATA_W-1:0]   threshold,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               found,
    output logic [mtff_pkg::POS_W-1:0]         match_index,
    output logic [mtff_pkg::DATA_W-1:0]        match_value
);

    mtff_pkg::ram_req_t           ram_req;
    logic [mtff_pkg::DATA_W-1:0]  rd_data;
    logic [mtff_pkg::DATA_W-1:0]  cmp_b;
    mtff_pkg::cmp_res_t           cmp_res;

    // Control and handshakes
    mtff_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .position    (position),
        .range_end   (range_end),
        .leaf_value  (leaf_value),
        .threshold   (threshold),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .match_index (match_index),
        .match_value (match_value),
        .ram_req     (ram_req),
        .rd_data     (rd_data),
        .cmp_b       (cmp_b),
        .cmp_res     (cmp_res)
    );

    // Shared compare against memory read data
    mtff_cmp u_cmp (
        .a   (rd_data),
        .b   (cmp_b),
        .res (cmp_res)
    );

    // Node minimum store
    mtff_tree_ram u_ram (
        .clk     (clk),
        .req     (ram_req),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

/* design/mtff_checker.sv */
// Port-level checker for the min-tree first-fit engine, bound to the top level.
// Depends on mtff_pkg for field widths and the empty code.
`default_nettype none

module mtff_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic [mtff_pkg::FUNC_W-1:0]   func,
    input wire logic [mtff_pkg::POS_W-1:0]    position,
    input wire logic [mtff_pkg::POS_W-1:0]    range_end,
    input wire logic [mtff_pkg::DATA_W-1:0]   leaf_value,
    input wire logic [mtff_pkg::DATA_W-1:0]   threshold,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic                          found,
    input wire logic [mtff_pkg::POS_W-1:0]    match_index,
    input wire logic [mtff_pkg::DATA_W-1:0]   match_value
);

    // Hold a stalled input beat
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(func) && $stable(position) &&
        $stable(range_end) && $stable(leaf_value) && $stable(threshold))
        else $error("input beat changed while stalled");

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found) &&
        $stable(match_index) && $stable(match_value))
        else $error("result beat changed while stalled");

    // One operation in flight: busy right after an accepted beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a second beat while busy");

    // Miss results carry zero index and value
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> match_index == '0 && match_value == '0)
        else $error("miss result with nonzero fields");

    // A hit never reports an empty leaf
    a_hit_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> match_value != mtff_pkg::EMPTY_MARK)
        else $error("hit on an empty leaf");

endmodule

bind min_tree_first_fit_engine_core mtff_checker u_mtff_checker (.*);

`default_nettype wire

/* tb/testbench.sv */
// Self-checking bench for min_tree_first_fit_engine_core: a directed table, then random loads,
// removes, first-fit finds and unused codes, each beat checked against a leaf-array predictor
// or, for typed directed rows, a literal. Depends on mtff_pkg and the core RTL.
`default_nettype none

module testbench;

    localparam logic [mtff_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1526;
    localparam int CALM_TAIL    = 200;
    localparam int DRAIN_CYCLES = 40;
    localparam int LIMIT_CYCLES = 400000;

    typedef struct packed {
        logic                        found;
        logic [mtff_pkg::POS_W-1:0]  slot;
        logic [mtff_pkg::DATA_W-1:0] value;
    } fit_result_t;

    typedef struct packed {
        logic [mtff_pkg::FUNC_W-1:0] op;
        logic [mtff_pkg::POS_W-1:0]  pos;
        logic [mtff_pkg::POS_W-1:0]  last;
        logic [mtff_pkg::DATA_W-1:0] val;
        logic [mtff_pkg::DATA_W-1:0] thr;
        logic                        typed;
        fit_result_t                 want;
    } op_row_t;

    localparam fit_result_t NIL = '0;
    localparam int DIRECTED_ROWS = 24;

    // Directed rows; where typed is set the expected beat is the literal, else the predictor's
    localparam op_row_t DIRECTED [DIRECTED_ROWS] = '{
        // find on an empty store: empty leaves never match
        '{mtff_pkg::FUNC_FIND, 10'd0, 10'd1023, 32'h0, 32'hFFFF_FFFF, 1'b1, NIL},
        '{mtff_pkg::FUNC_LOAD, 10'd0, 10'd0, 32'h0, 32'h0, 1'b1, NIL},
        // load of all ones saturates to the top value
        '{mtff_pkg::FUNC_LOAD, 10'd1023, 10'd0, 32'hFFFF_FFFF, 32'h0, 1'b1, NIL},
        '{mtff_pkg::FUNC_FIND, 10'd0, 10'd1023, 32'h0, 32'h0, 1'b1,
          '{1'b1, 10'd0, 32'h0}},
        '{mtff_pkg::FUNC_FIND, 10'd1, 10'd1023, 32'h0, 32'hFFFF_FFFF, 1'b1,
          '{1'b1, 10'd1023, 32'hFFFF_FFFE}},
        '{mtff_pkg::FUNC_FIND, 10'd1, 10'd1023, 32'h0, 32'hFFFF_FFFD, 1'b1, NIL},
        // empty range: start past end
        '{mtff_pkg::FUNC_FIND, 10'd1023, 10'd0, 32'h0, 32'hFFFF_FFFF, 1'b1, NIL},
        // unused code with every bit set: no state change
        '{FUNC_UNUSED, 10'h3FF, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, NIL},
        '{mtff_pkg::FUNC_REMOVE, 10'd0, 10'd0, 32'h0, 32'h0, 1'b1, NIL},
        '{mtff_pkg::FUNC_FIND, 10'd0, 10'd0, 32'h0, 32'hFFFF_FFFF, 1'b1, NIL},
        // remove of an already empty leaf
        '{mtff_pkg::FUNC_REMOVE, 10'd0, 10'd0, 32'h0, 32'h0, 1'b1, NIL},
        '{mtff_pkg::FUNC_FIND, 10'd0, 10'd1022, 32'h0, 32'hFFFF_FFFF, 1'b1, NIL},
        '{mtff_pkg::FUNC_LOAD, 10'd3, 10'd0, 32'h1, 32'h0, 1'b1, NIL},
        '{mtff_pkg::FUNC_LOAD, 10'd511, 10'd0, 32'h9, 32'h0, 1'b0, NIL},
        '{mtff_pkg::FUNC_LOAD, 10'd512, 10'd0, 32'h7, 32'h0, 1'b0, NIL},
        // left subtree minimum fits but lies outside the range: backtrack
        '{mtff_pkg::FUNC_FIND, 10'd4, 10'd1023, 32'h0, 32'h8, 1'b0, NIL},
        '{mtff_pkg::FUNC_FIND, 10'd0, 10'd1023, 32'h0, 32'h0, 1'b0, NIL},
        '{mtff_pkg::FUNC_FIND, 10'd3, 10'd3, 32'h0, 32'h1, 1'b0, NIL},
        '{mtff_pkg::FUNC_LOAD, 10'd700, 10'd0, 32'hFFFF_FFFE, 32'h0, 1'b0, NIL},
        '{mtff_pkg::FUNC_FIND, 10'd513, 10'd1023, 32'h0, 32'hFFFF_FFFE, 1'b0, NIL},
        '{mtff_pkg::FUNC_REMOVE, 10'd1023, 10'd0, 32'h0, 32'h0, 1'b0, NIL},
        '{mtff_pkg::FUNC_FIND, 10'd701, 10'd1023, 32'h0, 32'hFFFF_FFFF, 1'b0, NIL},
        '{mtff_pkg::FUNC_LOAD, 10'd2, 10'h2AA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, NIL},
        '{mtff_pkg::FUNC_FIND, 10'd2, 10'd2, 32'h0, 32'h5555_5554, 1'b0, NIL}
    };

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic [mtff_pkg::FUNC_W-1:0] func;
    logic [mtff_pkg::POS_W-1:0]  position;
    logic [mtff_pkg::POS_W-1:0]  range_end;
    logic [mtff_pkg::DATA_W-1:0] leaf_value;
    logic [mtff_pkg::DATA_W-1:0] threshold;
    logic                        out_valid;
    logic                        out_ready;
    logic                        found;
    logic [mtff_pkg::POS_W-1:0]  match_index;
    logic [mtff_pkg::DATA_W-1:0] match_value;

    logic [mtff_pkg::DATA_W-1:0] leaf_store [mtff_pkg::LEAF_SLOTS];
    fit_result_t                 pending_fits [$];
    int                          mismatch_count;
    bit                          idle_on;
    int                          stall_left;

    min_tree_first_fit_engine_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .position    (position),
        .range_end   (range_end),
        .leaf_value  (leaf_value),
        .threshold   (threshold),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .match_index (match_index),
        .match_value (match_value)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one operation to the leaf array and return the beat it should produce
    function automatic fit_result_t apply_leaf_op(input op_row_t s);
        fit_result_t r;
        int          i;
        r = NIL;
        case (s.op)
            mtff_pkg::FUNC_LOAD:
                leaf_store[s.pos] = (s.val > mtff_pkg::TOP_VALUE) ?
                                    mtff_pkg::TOP_VALUE : s.val;
            mtff_pkg::FUNC_REMOVE:
                leaf_store[s.pos] = mtff_pkg::EMPTY_MARK;
            mtff_pkg::FUNC_FIND:
            begin
                // leftmost non-empty leaf in range at or below the threshold
                for (i = int'(s.pos); i <= int'(s.last); i++)
                begin
                    if (!r.found && leaf_store[i] != mtff_pkg::EMPTY_MARK &&
                        leaf_store[i] <= s.thr)
                    begin
                        r.found = 1'b1;
                        r.slot  = mtff_pkg::POS_W'(i);
                        r.value = leaf_store[i];
                    end
                end
            end
            default: r = NIL;
        endcase
        return r;
    endfunction

    // Draw one random operation, clustered around a moving window of leaves
    function automatic op_row_t random_op(input logic [mtff_pkg::POS_W-1:0] window);
        op_row_t     s;
        int unsigned pick;
        int          stop;
        s = '0;
        pick = $urandom_range(0, 99);
        if (pick < 42)
            s.op = mtff_pkg::FUNC_LOAD;
        else if (pick < 57)
            s.op = mtff_pkg::FUNC_REMOVE;
        else if (pick < 97)
            s.op = mtff_pkg::FUNC_FIND;
        else
            s.op = FUNC_UNUSED;
        if ($urandom_range(0, 1) == 0)
            s.pos = window + mtff_pkg::POS_W'($urandom_range(0, 63));
        else
            s.pos = mtff_pkg::POS_W'($urandom);
        pick = $urandom_range(0, 9);
        if (pick < 6)
        begin
            stop = int'(s.pos) + int'($urandom_range(0, 96));
            s.last = (stop > mtff_pkg::LEAF_SLOTS - 1) ?
                     mtff_pkg::POS_W'(mtff_pkg::LEAF_SLOTS - 1) : mtff_pkg::POS_W'(stop);
        end
        else if (pick < 8)
            s.last = mtff_pkg::POS_W'(mtff_pkg::LEAF_SLOTS - 1);
        else
            s.last = mtff_pkg::POS_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 5)
            s.val = mtff_pkg::EMPTY_MARK;
        else if (pick < 8)
            s.val = mtff_pkg::TOP_VALUE;
        else if (pick < 10)
            s.val = '0;
        else if (pick < 55)
            s.val = mtff_pkg::DATA_W'($urandom_range(0, 255));
        else
            s.val = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            s.thr = mtff_pkg::EMPTY_MARK;
        else if (pick < 8)
            s.thr = mtff_pkg::TOP_VALUE;
        else if (pick < 10)
            s.thr = '0;
        else if (pick < 60)
            s.thr = mtff_pkg::DATA_W'($urandom_range(0, 255));
        else
            s.thr = $urandom;
        return s;
    endfunction

    // Present one beat, hold it until accepted, then queue its expected result
    task automatic offer_beat(input op_row_t s);
        fit_result_t predicted;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= s.op;
        position   <= s.pos;
        range_end  <= s.last;
        leaf_value <= s.val;
        threshold  <= s.thr;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = apply_leaf_op(s);
        pending_fits.push_back(s.typed ? s.want : predicted);
    endtask

    // Drop valid and hold off until every queued result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_fits.size() != 0)
            @(posedge clk);
    endtask

    task automatic log_mismatch(input string what, input fit_result_t want,
                                input fit_result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display({"mismatch (%s): expected found=%0d index=%0d value=%h, ",
                      "got found=%0d index=%0d value=%h"},
                     what, want.found, want.slot, want.value,
                     got.found, got.slot, got.value);
    endtask

    // Main stimulus
    initial
    begin
        logic [mtff_pkg::POS_W-1:0] window;
        int                         k;
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        func           = mtff_pkg::FUNC_LOAD;
        position       = '0;
        range_end      = '0;
        leaf_value     = '0;
        threshold      = '0;
        mismatch_count = 0;
        idle_on        = 1'b1;
        window         = '0;
        for (k = 0; k < mtff_pkg::LEAF_SLOTS; k++)
            leaf_store[k] = mtff_pkg::EMPTY_MARK;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < DIRECTED_ROWS; k++)
            offer_beat(DIRECTED[k]);
        drain_results();

        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            // alternate busy and calm stretches; keep the tail calm
            if (k % 64 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            if (k >= RANDOM_ITEMS - CALM_TAIL)
                idle_on = 1'b0;
            if (k % 32 == 0)
                window = mtff_pkg::POS_W'($urandom);
            if (k == RANDOM_ITEMS / 2)
                drain_results();
            offer_beat(random_op(window));
        end
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && pending_fits.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Receiver: stall out_ready in random bursts while idling is on
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 13) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    initial
    begin
        out_ready  = 1'b0;
        stall_left = 0;
    end

    // Check each result beat against the oldest expectation
    always @(posedge clk)
    begin : result_check
        fit_result_t got;
        fit_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{found, match_index, match_value};
            if (pending_fits.size() == 0)
                log_mismatch("no result pending", NIL, got);
            else
            begin
                want = pending_fits.pop_front();
                if (got.found !== want.found || got.slot !== want.slot ||
                    got.value !== want.value)
                    log_mismatch("field", want, got);
            end
        end
    end

    // Watchdog: end the run if it hangs
    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles", cycles);
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
